### rtl/core/pfg2d_pkg.sv
`default_nettype none
package pfg2d_pkg;

  // grid limits and memory geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int DEPTH      = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DIM_W      = 7;
  localparam int IDX_W      = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int DATA_W     = 32;
  localparam int NUM_FIELDS = 6;

  // fixed point
  localparam int FRAC  = 18;
  localparam int HALF  = 131072;
  localparam int WGT_W = 20;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_GATHER = 1'b1;

  // field select codes
  localparam logic [2:0] FLD_EX = 3'd0;
  localparam logic [2:0] FLD_EY = 3'd1;
  localparam logic [2:0] FLD_EZ = 3'd2;
  localparam logic [2:0] FLD_BX = 3'd3;
  localparam logic [2:0] FLD_BY = 3'd4;
  localparam logic [2:0] FLD_BZ = 3'd5;
  localparam logic [2:0] LANE_FIELD [NUM_FIELDS] =
    '{FLD_EX, FLD_EY, FLD_EZ, FLD_BX, FLD_BY, FLD_BZ};

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y     = 3'd5;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef wgt_t [2:0] wgt3_t;

  // per-axis stencil setup
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] lo_c;
    logic [IDX_W-1:0] lo_h;
    wgt3_t            w_c;
    wgt3_t            w_h;
  } axis_res_t;

  // stencil position of one memory read
  typedef struct packed {
    logic       v;
    logic [1:0] i;
    logic [1:0] j;
  } step_tag_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
  } lane_res_t;

endpackage
`default_nettype wire

### rtl/core/pfg2d_ifs.sv
`default_nettype none
interface pfg2d_in_if;
  import pfg2d_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [2:0]          field_select;
  logic [11:0]         cell_address;
  logic signed [31:0]  cell_value;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  modport source (output valid, command, field_select, cell_address, cell_value,
                  pos_x, pos_y, input ready);
  modport sink (input valid, command, field_select, cell_address, cell_value,
                pos_x, pos_y, output ready);
endinterface

interface pfg2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] e_x;
  logic signed [31:0] e_y;
  logic signed [31:0] e_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic               out_of_range;
  modport source (output valid, e_x, e_y, e_z, b_x, b_y, b_z, out_of_range,
                  input ready);
  modport sink (input valid, e_x, e_y, e_z, b_x, b_y, b_z, out_of_range,
                output ready);
endinterface

interface pfg2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/pic_field_gather_2d.sv
`default_nettype none
// channel   | dir | beat
// items     | in  | command, field_select, cell_address, cell_value, pos_x, pos_y
// results   | out | e_x, e_y, e_z, b_x, b_y, b_z, out_of_range
// cfg       | in  | index, data (register write)
//
// Write beats are accepted only while idle. A gather runs the coordinate
// pipeline and, if in range, computes the stencil base addresses, makes 9
// single-port memory reads (one stencil cell per cycle, six fields in
// parallel), drains the multiply-accumulate lanes and loads the output register.
// Synchronous reset clears control state; field memories are not cleared.
// A held result stalls only the end of the next gather, not its acceptance.
module pic_field_gather_2d
  import pfg2d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  pfg2d_in_if.sink    items,
  pfg2d_out_if.source results,
  pfg2d_cfg_if.sink   cfg
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AXIS  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;

  logic [DIM_W-1:0] grid_cols, grid_rows, cols_eff, rows_eff;
  logic [31:0]      origin_x, origin_y, inv_spacing_x, inv_spacing_y;

  logic               in_acc, wr_acc, gather_start, addr_ok;
  logic signed [31:0] pos_x, pos_y;
  axis_res_t          ax_x, ax_y;
  logic               ax_done_x, ax_done_y;

  logic [ADDR_W-1:0] base_a, base_b, base_c, base_d;
  logic [ADDR_W-1:0] ioff;
  logic [1:0]        si, sj;
  logic [ADDR_W-1:0] step_off;
  step_tag_t         tag_issue, tag_d;
  logic              res_oor;

  logic [ADDR_W-1:0]        lane_addr [NUM_FIELDS];
  logic                     ram_we    [NUM_FIELDS];
  logic [ADDR_W-1:0]        ram_addr  [NUM_FIELDS];
  logic [DATA_W-1:0]        rdata     [NUM_FIELDS];
  wgt3_t                    lane_wx   [NUM_FIELDS];
  wgt3_t                    lane_wy   [NUM_FIELDS];
  lane_res_t                lane_res  [NUM_FIELDS];

  // handshakes
  assign items.ready  = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;
  assign in_acc       = items.valid && items.ready;
  assign wr_acc       = in_acc && (items.command == CMD_WRITE);
  assign gather_start = in_acc && (items.command == CMD_GATHER);
  assign addr_ok      = ({1'b0, items.cell_address} < 13'(DEPTH));

  // grid size clamped to the memory geometry
  assign cols_eff = (grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols;
  assign rows_eff = (grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols     <= DIM_W'(64);
      grid_rows     <= DIM_W'(64);
      origin_x      <= '0;
      origin_y      <= '0;
      inv_spacing_x <= 32'd16777216;
      inv_spacing_y <= 32'd16777216;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GRID_COLS: grid_cols     <= cfg.data[DIM_W-1:0];
        REG_GRID_ROWS: grid_rows     <= cfg.data[DIM_W-1:0];
        REG_ORIGIN_X:  origin_x      <= cfg.data;
        REG_ORIGIN_Y:  origin_y      <= cfg.data;
        REG_INV_X:     inv_spacing_x <= cfg.data;
        REG_INV_Y:     inv_spacing_y <= cfg.data;
        default: ;
      endcase
    end
  end

  assign pos_x = items.pos_x;
  assign pos_y = items.pos_y;

  // coordinate pipelines
  pfg2d_axis u_axis_x (
    .clk(clk), .rst(rst), .start(gather_start), .pos(pos_x), .org(origin_x),
    .inv(inv_spacing_x), .n(cols_eff), .res(ax_x), .done(ax_done_x)
  );

  pfg2d_axis u_axis_y (
    .clk(clk), .rst(rst), .start(gather_start), .pos(pos_y), .org(origin_y),
    .inv(inv_spacing_y), .n(rows_eff), .res(ax_y), .done(ax_done_y)
  );

  // stencil addresses for the four stagger pairings
  assign step_off = ioff + ADDR_W'(sj);
  always_comb begin
    lane_addr[0] = base_c + step_off;
    lane_addr[1] = base_b + step_off;
    lane_addr[2] = base_a + step_off;
    lane_addr[3] = base_b + step_off;
    lane_addr[4] = base_c + step_off;
    lane_addr[5] = base_d + step_off;
    lane_wx[0] = ax_x.w_h;  lane_wy[0] = ax_y.w_c;
    lane_wx[1] = ax_x.w_c;  lane_wy[1] = ax_y.w_h;
    lane_wx[2] = ax_x.w_c;  lane_wy[2] = ax_y.w_c;
    lane_wx[3] = ax_x.w_c;  lane_wy[3] = ax_y.w_h;
    lane_wx[4] = ax_x.w_h;  lane_wy[4] = ax_y.w_c;
    lane_wx[5] = ax_x.w_h;  lane_wy[5] = ax_y.w_h;
  end

  assign tag_issue = '{v: (state == ST_RUN), i: si, j: sj};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tag_d   <= '0;
      results.valid <= 1'b0;
    end else begin
      tag_d <= tag_issue;
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (gather_start) begin
            state <= ST_AXIS;
          end
        end
        ST_AXIS: begin
          if (ax_done_x && ax_done_y) begin
            res_oor <= !(ax_x.ok && ax_y.ok);
            state   <= (ax_x.ok && ax_y.ok) ? ST_SETUP : ST_OUT;
          end
        end
        ST_SETUP: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (si == 2'd2 && sj == 2'd2) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (lane_res[0].done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // stencil walk: column inner, row outer
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      base_a <= ADDR_W'(ax_x.lo_c * rows_eff) + ADDR_W'(ax_y.lo_c);
      base_b <= ADDR_W'(ax_x.lo_c * rows_eff) + ADDR_W'(ax_y.lo_h);
      base_c <= ADDR_W'(ax_x.lo_h * rows_eff) + ADDR_W'(ax_y.lo_c);
      base_d <= ADDR_W'(ax_x.lo_h * rows_eff) + ADDR_W'(ax_y.lo_h);
      si     <= 2'd0;
      sj     <= 2'd0;
      ioff   <= '0;
    end else if (state == ST_RUN) begin
      if (si == 2'd2) begin
        si   <= 2'd0;
        sj   <= sj + 2'd1;
        ioff <= '0;
      end else begin
        si   <= si + 2'd1;
        ioff <= ioff + ADDR_W'(rows_eff);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!results.valid || results.ready)) begin
      results.e_x          <= res_oor ? '0 : lane_res[0].value;
      results.e_y          <= res_oor ? '0 : lane_res[1].value;
      results.e_z          <= res_oor ? '0 : lane_res[2].value;
      results.b_x          <= res_oor ? '0 : lane_res[3].value;
      results.b_y          <= res_oor ? '0 : lane_res[4].value;
      results.b_z          <= res_oor ? '0 : lane_res[5].value;
      results.out_of_range <= res_oor;
    end
  end

  // field memories and accumulate lanes
  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
    assign ram_we[k]   = wr_acc && addr_ok && (items.field_select == LANE_FIELD[k]);
    assign ram_addr[k] = (state == ST_IDLE) ? items.cell_address[ADDR_W-1:0]
                                            : lane_addr[k];

    pfg2d_ram #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_ram (
      .clk(clk), .we(ram_we[k]), .addr(ram_addr[k]),
      .wdata(items.cell_value), .rdata(rdata[k])
    );

    pfg2d_lane u_lane (
      .clk(clk), .rst(rst), .tag(tag_d), .rdata($signed(rdata[k])),
      .wx(lane_wx[k]), .wy(lane_wy[k]), .res(lane_res[k])
    );
  end

  // checks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.out_of_range |->
      results.e_x == 0 && results.e_y == 0 && results.e_z == 0 &&
      results.b_x == 0 && results.b_y == 0 && results.b_z == 0)
    else $error("out-of-range result with nonzero field");

  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    (ram_we[0] || ram_we[1] || ram_we[2] || ram_we[3] || ram_we[4] || ram_we[5])
      |-> state == ST_IDLE)
    else $error("field write during gather");

  a_done_drain: assert property (@(posedge clk) disable iff (rst)
    lane_res[0].done |-> state == ST_DRAIN)
    else $error("lane finished outside drain");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lane_res[0].done |-> lane_res[5].done && lane_res[2].done)
    else $error("lanes out of step");

endmodule
`default_nettype wire

### rtl/core/pfg2d_ram.sv
`default_nettype none
module pfg2d_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### rtl/core/pfg2d_axis.sv
`default_nettype none
module pfg2d_axis
  import pfg2d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] pos,
  input  wire logic        [31:0] org,
  input  wire logic        [31:0] inv,
  input  wire logic [DIM_W-1:0]   n,
  output axis_res_t               res,
  output logic                    done
);

  localparam int IW = 19;

  logic [6:0] v;

  logic signed [32:0] d;
  logic               neg2, neg3;
  logic        [32:0] m;
  logic        [48:0] ph, pl;
  logic        [56:0] p;
  logic signed [36:0] s_next, s;
  logic signed [36:0] t;
  logic signed [IW-1:0] i1, i2;
  logic               ok5, ok6;
  logic [IDX_W-1:0]   lo1_5, lo2_5, lo1_6, lo2_6;
  logic signed [IW-1:0] dc5, dh5, dc6, dh6;
  logic signed [37:0] sqc, sqh;

  function automatic logic in_rng(logic signed [IW-1:0] i, logic [DIM_W-1:0] nn);
    logic signed [IW:0] ie, ne;
    ie = (IW+1)'(i);
    ne = $signed({{(IW+1-DIM_W){1'b0}}, nn});
    return (ie >= 20'sd1) && (ie + 20'sd2 <= ne);
  endfunction

  function automatic wgt3_t weights(logic signed [IW-1:0] dl, logic signed [37:0] sq);
    logic signed [20:0] d2, a0, a2;
    wgt3_t w;
    d2 = 21'((sq + 38'sd131072) >>> FRAC);
    a0 = 21'sd65536 + d2 + 21'(dl);
    a2 = 21'sd65536 + d2 - 21'(dl);
    w[0] = WGT_W'(a0 >>> 1);
    w[1] = WGT_W'(21'sd196608 - d2);
    w[2] = WGT_W'(a2 >>> 1);
    return w;
  endfunction

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], start};
    end
  end

  // scaled coordinate from the two partial products, saturated
  always_comb begin
    p = (|ph[48:40]) ? (57'(1) << 56) : ((57'(ph) << 16) + 57'(pl));
    s_next = neg3 ? -(37'((p + 57'(22'h3fffff)) >> 22)) : 37'(p >> 22);
    t  = s + 37'(HALF);
    i1 = t[36:FRAC];
    i2 = s[36:FRAC];
  end

  // offset, magnitude, multiply, scale, index, square, weights
  always_ff @(posedge clk) begin
    if (start) begin
      d <= $signed({pos[31], pos}) - $signed({org[31], org});
    end
    if (v[0]) begin
      neg2 <= d[32];
      m    <= d[32] ? 33'(-d) : 33'(d);
    end
    if (v[1]) begin
      neg3 <= neg2;
      ph   <= 49'(m * inv[31:16]);
      pl   <= 49'(m * inv[15:0]);
    end
    if (v[2]) begin
      s <= s_next;
    end
    if (v[3]) begin
      ok5   <= in_rng(i1, n) && in_rng(i2, n);
      lo1_5 <= IDX_W'(i1 - 19'sd1);
      lo2_5 <= IDX_W'(i2 - 19'sd1);
      dc5   <= 19'sd131072 - $signed({1'b0, t[FRAC-1:0]});
      dh5   <= 19'sd131072 - $signed({1'b0, s[FRAC-1:0]});
    end
    if (v[4]) begin
      ok6   <= ok5;
      lo1_6 <= lo1_5;
      lo2_6 <= lo2_5;
      dc6   <= dc5;
      dh6   <= dh5;
      sqc   <= dc5 * dc5;
      sqh   <= dh5 * dh5;
    end
    if (v[5]) begin
      res.ok   <= ok6;
      res.lo_c <= lo1_6;
      res.lo_h <= lo2_6;
      res.w_c  <= weights(dc6, sqc);
      res.w_h  <= weights(dh6, sqh);
    end
  end

  assign done = v[6];

endmodule
`default_nettype wire

### rtl/core/pfg2d_lane.sv
`default_nettype none
module pfg2d_lane
  import pfg2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire step_tag_t                tag,
  input  wire logic signed [DATA_W-1:0] rdata,
  input  wire wgt3_t                    wx,
  input  wire wgt3_t                    wy,
  output lane_res_t                     res
);

  localparam int PROD_W = WGT_W + DATA_W;
  localparam int ROW_W  = PROD_W + 2;
  localparam int ROWQ_W = 34;
  localparam int YP_W   = WGT_W + ROWQ_W;
  localparam int ACC_W  = YP_W + 2;

  step_tag_t tag2, tag3, tag4;
  wgt_t      w_x, w_y;

  logic signed [PROD_W-1:0] prod;
  logic signed [ROW_W-1:0]  row, row_base, row_new, row_rnd;
  logic signed [ROWQ_W-1:0] rowq;
  logic signed [YP_W-1:0]   yprod;
  logic signed [ACC_W-1:0]  acc, acc_base, acc_new, acc_rnd;
  logic                     ovf;
  logic signed [DATA_W-1:0] sat_val;

  // weight pick for the current stencil column and row
  always_comb begin
    case (tag.i)
      2'd0:    w_x = wx[0];
      2'd1:    w_x = wx[1];
      2'd2:    w_x = wx[2];
      default: w_x = '0;
    endcase
    case (tag3.j)
      2'd0:    w_y = wy[0];
      2'd1:    w_y = wy[1];
      2'd2:    w_y = wy[2];
      default: w_y = '0;
    endcase
  end

  // row sum, rounding and final saturation
  always_comb begin
    row_base = (tag2.i == 2'd0) ? '0 : row;
    row_new  = row_base + ROW_W'(prod);
    row_rnd  = (row_new + ROW_W'(HALF)) >>> FRAC;
    acc_base = (tag4.j == 2'd0) ? '0 : acc;
    acc_new  = acc_base + ACC_W'(yprod);
    acc_rnd  = (acc_new + ACC_W'(HALF)) >>> FRAC;
    ovf      = !((&acc_rnd[ACC_W-1:DATA_W-1]) || !(|acc_rnd[ACC_W-1:DATA_W-1]));
    if (ovf) begin
      sat_val = acc_rnd[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_val = acc_rnd[DATA_W-1:0];
    end
  end

  // beat tags
  always_ff @(posedge clk) begin
    if (rst) begin
      tag2     <= '0;
      tag3     <= '0;
      tag4     <= '0;
      res.done <= 1'b0;
    end else begin
      tag2     <= tag;
      tag3     <= '{v: tag2.v && (tag2.i == 2'd2), i: tag2.i, j: tag2.j};
      tag4     <= tag3;
      res.done <= tag4.v && (tag4.j == 2'd2);
    end
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk) begin
    if (tag.v) begin
      prod <= PROD_W'(w_x * rdata);
    end
    if (tag2.v) begin
      row  <= row_new;
      rowq <= ROWQ_W'(row_rnd);
    end
    if (tag3.v) begin
      yprod <= YP_W'(w_y * rowq);
    end
    if (tag4.v) begin
      acc <= acc_new;
      if (tag4.j == 2'd2) begin
        res.value <= sat_val;
      end
    end
  end

endmodule
`default_nettype wire
